### sv/sbfd_pkg.sv
package sbfd_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam int FRAME_LEN = 25;
  localparam int STORE_LEN = 23;
  localparam int FLAGS_POS = 22;
  localparam int CHANNELS = 16;
  localparam int CH_W = 11;
  localparam int RAM_DEPTH = 2 * STORE_LEN;
  localparam int ADDR_W = $clog2(RAM_DEPTH);

  localparam logic [4:0] LAST_COUNT = 5'(FRAME_LEN - 1);
  localparam logic [4:0] FLAGS_IDX = 5'(FLAGS_POS);
  localparam logic [3:0] LAST_CHAN = 4'(CHANNELS - 1);
  localparam logic [4:0] CH_BITS = 5'(CH_W);

  typedef struct packed {
    logic [3:0] channel_index;
    logic [10:0] channel_value;
    logic connected;
    logic last;
  } res_t;

  function automatic logic [ADDR_W-1:0] ram_addr(input logic bank, input logic [4:0] idx);
    ram_addr = ADDR_W'(idx) + (bank ? ADDR_W'(STORE_LEN) : ADDR_W'(0));
  endfunction

endpackage

### sv/sbfd_ram.sv
module sbfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 46
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/sbfd_unpack.sv
module sbfd_unpack import sbfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic start_bank,
  output logic busy,
  output logic rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0] rd_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAGS,
    S_FILL,
    S_EMIT,
    S_DISC
  } state_t;

  state_t state;
  logic bank;
  logic [4:0] ptr;
  logic [17:0] acc;
  logic [4:0] nbits;
  logic [3:0] chan;

  logic out_free;
  logic emit_now;
  logic rd_bank;
  logic [4:0] rd_idx;
  logic [17:0] acc_app;
  logic [4:0] nbits_app;
  logic [4:0] nbits_left;

  assign out_free = !out_valid || out_ready;
  assign emit_now = (state inside {S_EMIT, S_DISC}) && out_free;
  assign busy = (state != S_IDLE);
  assign rd_bank = (state == S_IDLE) ? start_bank : bank;
  assign rd_addr = ram_addr(rd_bank, rd_idx);
  assign acc_app = acc | (18'(rd_data) << nbits);
  assign nbits_app = nbits + 5'd8;
  assign nbits_left = nbits - CH_BITS;

  always_comb begin
    rd_en = 1'b0;
    rd_idx = FLAGS_IDX;
    case (state)
      S_IDLE: begin
        rd_en = start;
      end
      S_FLAGS: begin
        if (rd_data == 8'd0) begin
          rd_en = 1'b1;
          rd_idx = 5'd0;
        end
      end
      S_FILL: begin
        if (nbits_app < CH_BITS) begin
          rd_en = 1'b1;
          rd_idx = ptr;
        end
      end
      S_EMIT: begin
        if (out_free && chan != LAST_CHAN && nbits_left < CH_BITS) begin
          rd_en = 1'b1;
          rd_idx = ptr;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_now) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            bank <= start_bank;
            state <= S_FLAGS;
          end
        end
        S_FLAGS: begin
          acc <= '0;
          nbits <= '0;
          chan <= '0;
          ptr <= 5'd1;
          state <= (rd_data == 8'd0) ? S_FILL : S_DISC;
        end
        S_FILL: begin
          acc <= acc_app;
          nbits <= nbits_app;
          if (nbits_app >= CH_BITS) begin
            state <= S_EMIT;
          end else begin
            ptr <= ptr + 5'd1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_res.channel_index <= chan;
            out_res.channel_value <= acc[10:0];
            out_res.connected <= 1'b1;
            out_res.last <= (chan == LAST_CHAN);
            acc <= acc >> CH_W;
            nbits <= nbits_left;
            chan <= chan + 4'd1;
            if (chan == LAST_CHAN) begin
              state <= S_IDLE;
            end else if (nbits_left < CH_BITS) begin
              ptr <= ptr + 5'd1;
              state <= S_FILL;
            end
          end
        end
        S_DISC: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_res.channel_index <= '0;
            out_res.channel_value <= '0;
            out_res.connected <= 1'b0;
            out_res.last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/sbus_frame_decoder.sv
// when the end byte is taken the flags byte is read first; a nonzero flags byte gives one disconnected result
// throughput: one byte per cycle while in_ready is high
// the emitter reads the frame store byte by byte through a single read port
// the end byte waits while the previous frame drains
// reset: synchronous, clears the byte counter, bank select and output valid
// the frame store is not cleared; each entry is written before it is read
module sbus_frame_decoder import sbfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] rx_byte,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] channel_index,
  output logic [10:0] channel_value,
  output logic connected,
  output logic last
);

  logic [4:0] byte_count;
  logic wr_bank;
  logic busy;
  logic accept;
  logic we;
  logic start;
  logic rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0] rd_data;
  res_t out_res;

  assign in_ready = !(byte_count == LAST_COUNT && busy);
  assign accept = in_valid && in_ready;
  assign we = accept && byte_count != 5'd0 && byte_count != LAST_COUNT;
  assign start = accept && byte_count == LAST_COUNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      wr_bank <= 1'b0;
    end else if (accept) begin
      if (byte_count == 5'd0) begin
        if (rx_byte == HEADER_BYTE) begin
          byte_count <= 5'd1;
        end
      end else if (byte_count == LAST_COUNT) begin
        byte_count <= '0;
        wr_bank <= !wr_bank;
      end else begin
        byte_count <= byte_count + 5'd1;
      end
    end
  end

  sbfd_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk(clk),
    .we(we),
    .waddr(ram_addr(wr_bank, byte_count - 5'd1)),
    .wdata(rx_byte),
    .re(rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  sbfd_unpack u_unpack (
    .clk(clk),
    .rst(rst),
    .start(start),
    .start_bank(wr_bank),
    .busy(busy),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res(out_res)
  );

  assign channel_index = out_res.channel_index;
  assign channel_value = out_res.channel_value;
  assign connected = out_res.connected;
  assign last = out_res.last;

endmodule

### sv/sbfd_checker.sv
module sbfd_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [3:0] channel_index,
  input logic [10:0] channel_value,
  input logic connected,
  input logic last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel_index)
      && $stable(channel_value) && $stable(connected) && $stable(last))
    else $error("stalled word changed");

  a_disc: assert property (@(posedge clk) disable iff (rst)
    out_valid && !connected |-> last && channel_index == 4'd0 && channel_value == 11'd0)
    else $error("bad disconnected word");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && connected |-> (last == (channel_index == 4'd15)))
    else $error("last flag does not match final channel");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind sbus_frame_decoder sbfd_checker u_sbfd_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .channel_index(channel_index),
  .channel_value(channel_value),
  .connected(connected),
  .last(last)
);
